/* rtl/core/range_count_floored_divider_defines.svh */
// Assertion macros for the range count divider RTL.
// No dependencies; include by bare file name.
`ifndef RANGE_COUNT_FLOORED_DIVIDER_DEFINES_SVH
`define RANGE_COUNT_FLOORED_DIVIDER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RCFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcfd check failed");

// Next-cycle implication, disabled in reset
`define RCFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcfd check failed");

`endif

/* rtl/core/rcfd_pkg.sv */
// Package for the range count floored divider: widths, error codes, scale tables.
// No dependencies.
package rcfd_pkg;

   localparam int VALUE_WIDTH       = 64;
   localparam int MAX_DECIMAL_SCALE = 18;
   localparam int QUOT_WIDTH        = 64;
   localparam int WIDE_WIDTH        = 2 * QUOT_WIDTH;
   localparam logic [4:0] DT_MAX_SCALE = 5'd9;
   localparam logic [4:0] IV_FIRST     = 5'd10;
   localparam logic [4:0] IV_LAST      = 5'd17;
   localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_ZERO_STEP = 2'd1,
      ERR_TOO_MANY  = 2'd2,
      ERR_UNIT      = 2'd3
   } err_type;

   typedef struct packed {
      logic    valid;
      err_type err;
      logic    empty;
   } ctl_type;

   // Powers of ten up to 10^18
   function automatic logic [63:0] pow_ten(input logic [4:0] idx);
      logic [63:0] r;
      case (idx)
         5'd0:    r = 64'd1;
         5'd1:    r = 64'd10;
         5'd2:    r = 64'd100;
         5'd3:    r = 64'd1000;
         5'd4:    r = 64'd10000;
         5'd5:    r = 64'd100000;
         5'd6:    r = 64'd1000000;
         5'd7:    r = 64'd10000000;
         5'd8:    r = 64'd100000000;
         5'd9:    r = 64'd1000000000;
         5'd10:   r = 64'd10000000000;
         5'd11:   r = 64'd100000000000;
         5'd12:   r = 64'd1000000000000;
         5'd13:   r = 64'd10000000000000;
         5'd14:   r = 64'd100000000000000;
         5'd15:   r = 64'd1000000000000000;
         5'd16:   r = 64'd10000000000000000;
         5'd17:   r = 64'd100000000000000000;
         5'd18:   r = 64'd1000000000000000000;
         default: r = 64'd0;
      endcase
      return r;
   endfunction

   // Nanoseconds per unit: datetime scale or interval kind
   function automatic logic [63:0] temporal_factor(input logic [4:0] unit);
      logic [63:0] r;
      logic [2:0]  kind;
      kind = 3'(unit - IV_FIRST);
      if (unit <= DT_MAX_SCALE) begin
         r = pow_ten(5'(DT_MAX_SCALE - unit));
      end else begin
         case (kind)
            3'd0:    r = 64'd1;
            3'd1:    r = 64'd1000;
            3'd2:    r = 64'd1000000;
            3'd3:    r = NS_PER_SEC;
            3'd4:    r = 64'd60 * NS_PER_SEC;
            3'd5:    r = 64'd3600 * NS_PER_SEC;
            3'd6:    r = 64'd86400 * NS_PER_SEC;
            default: r = 64'd604800 * NS_PER_SEC;
         endcase
      end
      return r;
   endfunction

endpackage

/* rtl/core/rcfd_divider.sv */
// Pipelined restoring divider: one quotient bit per stage.
// Depends on rcfd_pkg.
module rcfd_divider
   import rcfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  ctl_type               in_ctl,
   input  logic [WIDE_WIDTH-1:0] in_rem,
   input  logic [QUOT_WIDTH-1:0] in_nq,
   input  logic [WIDE_WIDTH-1:0] in_div,
   output ctl_type               out_ctl,
   output logic [QUOT_WIDTH-1:0] out_quot
);

   ctl_type               ctl_ff [QUOT_WIDTH];
   logic [WIDE_WIDTH-1:0] rem_ff [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] nq_ff  [QUOT_WIDTH];
   logic [WIDE_WIDTH-1:0] div_ff [QUOT_WIDTH];

   for (genvar k = 0; k < QUOT_WIDTH; k++) begin : g_stage
      ctl_type               cur_ctl;
      logic [WIDE_WIDTH-1:0] cur_rem;
      logic [QUOT_WIDTH-1:0] cur_nq;
      logic [WIDE_WIDTH-1:0] cur_div;
      logic [WIDE_WIDTH-1:0] trial_in;
      logic                  ge_in;

      // Select the stage input: module ports for the first stage
      if (k == 0) begin : g_first
         assign cur_ctl = in_ctl;
         assign cur_rem = in_rem;
         assign cur_nq  = in_nq;
         assign cur_div = in_div;
      end else begin : g_next
         assign cur_ctl = ctl_ff[k-1];
         assign cur_rem = rem_ff[k-1];
         assign cur_nq  = nq_ff[k-1];
         assign cur_div = div_ff[k-1];
      end

      // Shift in the next dividend bit and try the subtract
      assign trial_in = {cur_rem[WIDE_WIDTH-2:0], cur_nq[QUOT_WIDTH-1]};
      assign ge_in    = trial_in >= cur_div;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (enable) begin
            ctl_ff[k].valid <= cur_ctl.valid;
         end
         if (enable) begin
            ctl_ff[k].err   <= cur_ctl.err;
            ctl_ff[k].empty <= cur_ctl.empty;
            rem_ff[k]       <= ge_in ? trial_in - cur_div : trial_in;
            nq_ff[k]        <= {cur_nq[QUOT_WIDTH-2:0], ge_in};
            div_ff[k]       <= cur_div;
         end
      end
   end

   assign out_ctl  = ctl_ff[QUOT_WIDTH-1];
   assign out_quot = nq_ff[QUOT_WIDTH-1];

endmodule

/* rtl/core/range_count_floored_divider.sv */
// Range row counter: count = floor((to - from) / step) + 1, never below zero.
// Channels: req_* carries one row (mode, three values with unit codes),
// rsp_* carries row_count and error_code; both are valid/ready.
// Exact mode rescales all three values to the largest decimal scale;
// temporal mode converts datetimes and intervals to nanoseconds.
// Pipeline: 8 front stages (unit decode, 64x64 multiply in 32-bit partial
// products, span and sign handling), then 64 restoring divider stages, one
// quotient bit each, then the output register. Throughput: one row per
// cycle while the skid is empty.
// A stalled receiver: the output register holds the item and a one-item skid
// catches the next result; while the skid is full, the whole pipeline and
// req_ready hold. Reset empties the pipeline; no clearing pass is needed.
// Errors: 1 zero step, 2 count too large, 3 bad or mixed units; count is 0.
// Depends on rcfd_pkg, rcfd_divider and the defines header.
`include "range_count_floored_divider_defines.svh"

module range_count_floored_divider
   import rcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [63:0] req_from_value,
   input  logic [4:0]  req_from_unit,
   input  logic [63:0] req_to_value,
   input  logic [4:0]  req_to_unit,
   input  logic [63:0] req_step_value,
   input  logic [4:0]  req_step_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_row_count,
   output logic [1:0]  rsp_error_code
);

   logic en;

   // ---------------- stage 1: unit decode ----------------
   logic [2:0][63:0]      val_in;
   logic [2:0][4:0]       unit_in;
   logic [2:0][63:0]      fac_in;
   logic [4:0]            scale_in;
   logic                  bad_in;
   logic                  step_ok_in, both_dt_in, both_iv_in;
   ctl_type               s1_ctl_ff;
   logic [2:0][63:0]      s1_val_ff, s1_fac_ff;

   always_comb begin
      val_in[0]  = 64'($signed(req_from_value[VALUE_WIDTH-1:0]));
      val_in[1]  = 64'($signed(req_to_value[VALUE_WIDTH-1:0]));
      val_in[2]  = 64'($signed(req_step_value[VALUE_WIDTH-1:0]));
      unit_in[0] = req_from_unit;
      unit_in[1] = req_to_unit;
      unit_in[2] = req_step_unit;
      scale_in   = req_from_unit;
      if (req_to_unit > scale_in)   scale_in = req_to_unit;
      if (req_step_unit > scale_in) scale_in = req_step_unit;
      step_ok_in = req_step_unit >= IV_FIRST && req_step_unit <= IV_LAST;
      both_dt_in = req_from_unit <= DT_MAX_SCALE && req_to_unit <= DT_MAX_SCALE;
      both_iv_in = req_from_unit >= IV_FIRST && req_from_unit <= IV_LAST &&
                   req_to_unit >= IV_FIRST && req_to_unit <= IV_LAST;
      if (req_mode == 1'b0) begin
         bad_in = scale_in > 5'(MAX_DECIMAL_SCALE);
         for (int j = 0; j < 3; j++) fac_in[j] = pow_ten(5'(scale_in - unit_in[j]));
      end else begin
         bad_in = !step_ok_in || !(both_dt_in || both_iv_in);
         for (int j = 0; j < 3; j++) fac_in[j] = temporal_factor(unit_in[j]);
      end
   end

   // ---------------- stage 2: magnitudes ----------------
   ctl_type          s2_ctl_ff;
   logic [2:0]       s2_neg_ff;
   logic [2:0][63:0] s2_mag_ff, s2_fac_ff;

   // ---------------- stage 3: partial products ----------------
   ctl_type          s3_ctl_ff;
   logic [2:0]       s3_neg_ff;
   logic [2:0][63:0] s3_p00_ff, s3_p01_ff, s3_p10_ff, s3_p11_ff;

   // ---------------- stage 4: product sum ----------------
   ctl_type           s4_ctl_ff;
   logic [2:0]        s4_neg_ff;
   logic [2:0][127:0] s4_prod_ff;

   // ---------------- stage 5: signed products ----------------
   ctl_type           s5_ctl_ff;
   logic [2:0][127:0] s5_val_ff;

   // ---------------- stage 6: span ----------------
   ctl_type      s6_ctl_ff;
   logic [127:0] s6_span_ff, s6_step_ff;

   // ---------------- stage 7: classify ----------------
   ctl_type      s7_ctl_ff;
   logic [127:0] s7_span_ff, s7_step_ff;
   logic         span_neg_in, step_neg_in;

   // ---------------- stage 8: overflow check ----------------
   ctl_type      s8_ctl_ff;
   logic [127:0] s8_span_ff, s8_step_ff;
   logic         over_in;

   assign span_neg_in = s6_span_ff[127];
   assign step_neg_in = s6_step_ff[127];
   assign over_in     = {64'd0, s7_span_ff[127:64]} >= s7_step_ff;

   // Advance valid bits and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.valid <= 1'b0;
         s4_ctl_ff.valid <= 1'b0;
         s5_ctl_ff.valid <= 1'b0;
         s6_ctl_ff.valid <= 1'b0;
         s7_ctl_ff.valid <= 1'b0;
         s8_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ctl_ff.valid <= req_valid;
         s2_ctl_ff.valid <= s1_ctl_ff.valid;
         s3_ctl_ff.valid <= s2_ctl_ff.valid;
         s4_ctl_ff.valid <= s3_ctl_ff.valid;
         s5_ctl_ff.valid <= s4_ctl_ff.valid;
         s6_ctl_ff.valid <= s5_ctl_ff.valid;
         s7_ctl_ff.valid <= s6_ctl_ff.valid;
         s8_ctl_ff.valid <= s7_ctl_ff.valid;
      end

      if (en) begin
         s1_ctl_ff.err   <= bad_in ? ERR_UNIT : ERR_NONE;
         s1_ctl_ff.empty <= 1'b0;
         s1_val_ff       <= val_in;
         s1_fac_ff       <= fac_in;

         s2_ctl_ff.err   <= s1_ctl_ff.err;
         s2_ctl_ff.empty <= 1'b0;
         s2_fac_ff       <= s1_fac_ff;
         for (int j = 0; j < 3; j++) begin
            s2_neg_ff[j] <= s1_val_ff[j][63];
            s2_mag_ff[j] <= s1_val_ff[j][63] ? 64'd0 - s1_val_ff[j] : s1_val_ff[j];
         end

         s3_ctl_ff.err   <= s2_ctl_ff.err;
         s3_ctl_ff.empty <= 1'b0;
         s3_neg_ff       <= s2_neg_ff;
         for (int j = 0; j < 3; j++) begin
            s3_p00_ff[j] <= s2_mag_ff[j][31:0]  * s2_fac_ff[j][31:0];
            s3_p01_ff[j] <= s2_mag_ff[j][31:0]  * s2_fac_ff[j][63:32];
            s3_p10_ff[j] <= s2_mag_ff[j][63:32] * s2_fac_ff[j][31:0];
            s3_p11_ff[j] <= s2_mag_ff[j][63:32] * s2_fac_ff[j][63:32];
         end

         s4_ctl_ff.err   <= s3_ctl_ff.err;
         s4_ctl_ff.empty <= 1'b0;
         s4_neg_ff       <= s3_neg_ff;
         for (int j = 0; j < 3; j++) begin
            s4_prod_ff[j] <= {64'd0, s3_p00_ff[j]} + {32'd0, s3_p01_ff[j], 32'd0} +
                             {32'd0, s3_p10_ff[j], 32'd0} + {s3_p11_ff[j], 64'd0};
         end

         s5_ctl_ff.err   <= s4_ctl_ff.err;
         s5_ctl_ff.empty <= 1'b0;
         for (int j = 0; j < 3; j++) begin
            s5_val_ff[j] <= s4_neg_ff[j] ? 128'd0 - s4_prod_ff[j] : s4_prod_ff[j];
         end

         s6_ctl_ff.err   <= s5_ctl_ff.err;
         s6_ctl_ff.empty <= 1'b0;
         s6_span_ff      <= s5_val_ff[1] - s5_val_ff[0];
         s6_step_ff      <= s5_val_ff[2];

         // Zero step and empty range
         s7_ctl_ff.err   <= (s6_ctl_ff.err == ERR_NONE && s6_step_ff == 128'd0) ?
                            ERR_ZERO_STEP : s6_ctl_ff.err;
         s7_ctl_ff.empty <= s6_span_ff != 128'd0 && span_neg_in != step_neg_in;
         s7_span_ff      <= span_neg_in ? 128'd0 - s6_span_ff : s6_span_ff;
         s7_step_ff      <= step_neg_in ? 128'd0 - s6_step_ff : s6_step_ff;

         // Quotient of 2^64 or more
         s8_ctl_ff.err   <= (s7_ctl_ff.err == ERR_NONE && !s7_ctl_ff.empty && over_in) ?
                            ERR_TOO_MANY : s7_ctl_ff.err;
         s8_ctl_ff.empty <= s7_ctl_ff.empty;
         s8_span_ff      <= s7_span_ff;
         s8_step_ff      <= s7_step_ff;
      end
   end

   // ---------------- divider ----------------
   ctl_type     div_ctl;
   logic [63:0] div_quot;

   rcfd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_ctl   (s8_ctl_ff),
      .in_rem   ({64'd0, s8_span_ff[127:64]}),
      .in_nq    (s8_span_ff[63:0]),
      .in_div   (s8_step_ff),
      .out_ctl  (div_ctl),
      .out_quot (div_quot)
   );

   // ---------------- result and output ----------------
   logic [63:0] count_in;
   err_type     err_in;

   always_comb begin
      err_in   = div_ctl.err;
      count_in = 64'd0;
      if (err_in == ERR_NONE && !div_ctl.empty) begin
         if (div_quot == '1) err_in = ERR_TOO_MANY;
         else                count_in = div_quot + 64'd1;
      end
   end

   logic        out_valid_ff, skid_valid_ff;
   logic [63:0] out_count_ff, skid_count_ff;
   err_type     out_err_ff, skid_err_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // Hold result in the output register, catch the next one in the skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff  <= skid_valid_ff || div_ctl.valid;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= div_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_count_ff <= skid_valid_ff ? skid_count_ff : count_in;
         out_err_ff   <= skid_valid_ff ? skid_err_ff : err_in;
      end else if (en) begin
         skid_count_ff <= count_in;
         skid_err_ff   <= err_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_row_count  = out_count_ff;
   assign rsp_error_code = out_err_ff;

   // ---------------- checks ----------------
   `RCFD_ASSERT_NOW(a_err_zero_count, clock, reset,
      rsp_valid && rsp_error_code != ERR_NONE, rsp_row_count == 64'd0)
   `RCFD_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `RCFD_ASSERT_NEXT(a_skid_drains, clock, reset,
      skid_valid_ff && rsp_ready, out_valid_ff && !skid_valid_ff)

endmodule

/* bench/range_count_floored_divider_test.sv */
// Testbench for range_count_floored_divider: directed table, then random rows,
// each result checked against an in-bench floored-division row counter.
// Depends on rcfd_pkg and the range_count_floored_divider RTL.
`timescale 1ns / 1ps

module range_count_floored_divider_test
   import rcfd_pkg::*;
();

   localparam int LATENCY     = 72;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic        mode;
      logic [63:0] from_value;
      logic [4:0]  from_unit;
      logic [63:0] to_value;
      logic [4:0]  to_unit;
      logic [63:0] step_value;
      logic [4:0]  step_unit;
   } row_type;

   typedef struct {
      logic [63:0] row_count;
      err_type     error_code;
   } count_type;

   typedef struct {
      row_type   row;
      bit        typed;
      count_type want;
   } vector_type;

   localparam logic UNIT_EXACT    = 1'b0;
   localparam logic UNIT_TEMPORAL = 1'b1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [63:0] req_from_value;
   logic [4:0]  req_from_unit;
   logic [63:0] req_to_value;
   logic [4:0]  req_to_unit;
   logic [63:0] req_step_value;
   logic [4:0]  req_step_unit;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_row_count;
   logic [1:0]  rsp_error_code;

   count_type   pending_counts[$];
   int          error_count;
   int          cycle_count;
   bit          stall_enable;

   range_count_floored_divider dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_from_value(req_from_value), .req_from_unit(req_from_unit),
      .req_to_value(req_to_value), .req_to_unit(req_to_unit),
      .req_step_value(req_step_value), .req_step_unit(req_step_unit),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_count(rsp_row_count), .rsp_error_code(rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Scale factor: decimal power of ten
   function automatic logic [127:0] decimal_power(input int exponent);
      logic [127:0] p;
      p = 128'd1;
      for (int i = 0; i < exponent; i++) p = p * 128'd10;
      return p;
   endfunction

   // Scale factor: nanoseconds per datetime tick or interval kind
   function automatic logic [127:0] ns_per_unit(input logic [4:0] unit);
      case (unit)
         5'd10:   return 128'd1;
         5'd11:   return 128'd1000;
         5'd12:   return 128'd1000000;
         5'd13:   return 128'd1000000000;
         5'd14:   return 128'd60000000000;
         5'd15:   return 128'd3600000000000;
         5'd16:   return 128'd86400000000000;
         5'd17:   return 128'd604800000000000;
         default: return decimal_power(9 - int'(unit));
      endcase
   endfunction

   // Predict the row count for one row
   function automatic count_type count_rows(input row_type r);
      count_type           c;
      logic signed [127:0] f, t, s, span, mag_span, mag_step;
      logic [127:0]        q;
      int                  top;
      bit                  step_ok, both_dt, both_iv;
      c.row_count  = '0;
      c.error_code = ERR_NONE;
      f = 128'(signed'(r.from_value));
      t = 128'(signed'(r.to_value));
      s = 128'(signed'(r.step_value));
      if (r.mode == UNIT_EXACT) begin
         if (r.from_unit > 18 || r.to_unit > 18 || r.step_unit > 18) begin
            c.error_code = ERR_UNIT;
            return c;
         end
         top = r.from_unit;
         if (r.to_unit > top) top = r.to_unit;
         if (r.step_unit > top) top = r.step_unit;
         f = f * signed'(decimal_power(top - r.from_unit));
         t = t * signed'(decimal_power(top - r.to_unit));
         s = s * signed'(decimal_power(top - r.step_unit));
      end else begin
         step_ok = r.step_unit >= 10 && r.step_unit <= 17;
         both_dt = r.from_unit <= 9 && r.to_unit <= 9;
         both_iv = r.from_unit >= 10 && r.from_unit <= 17
                   && r.to_unit >= 10 && r.to_unit <= 17;
         if (!step_ok || !(both_dt || both_iv)) begin
            c.error_code = ERR_UNIT;
            return c;
         end
         f = f * signed'(ns_per_unit(r.from_unit));
         t = t * signed'(ns_per_unit(r.to_unit));
         s = s * signed'(ns_per_unit(r.step_unit));
      end
      span = t - f;
      if (s == 0) begin
         c.error_code = ERR_ZERO_STEP;
      end else if (span == 0) begin
         c.row_count = 64'd1;
      end else if ((span < 0) != (s < 0)) begin
         c.row_count = 64'd0;
      end else begin
         mag_span = span < 0 ? -span : span;
         mag_step = s < 0 ? -s : s;
         q = unsigned'(mag_span) / unsigned'(mag_step);
         if (q >= 128'hFFFF_FFFF_FFFF_FFFF) c.error_code = ERR_TOO_MANY;
         else c.row_count = q[63:0] + 64'd1;
      end
      return c;
   endfunction

   // Random row: mostly legal units, some noise
   function automatic row_type random_row();
      row_type r;
      int      pick;
      r.mode = 1'($urandom);
      for (int k = 0; k < 3; k++) begin
         logic [63:0] v;
         pick = $urandom_range(0, 9);
         case (pick)
            0:       v = {$urandom, $urandom};
            1:       v = 64'($signed($urandom_range(0, 20)) - 10);
            2:       v = {1'b1, 63'($urandom)};
            3:       v = {1'b0, {31{1'b1}}, $urandom};
            default: v = 64'($signed($urandom_range(0, 2000000)) - 1000000);
         endcase
         if (k == 0) r.from_value = v;
         else if (k == 1) r.to_value = v;
         else r.step_value = v;
      end
      if ($urandom_range(0, 9) == 0) begin
         r.from_unit = 5'($urandom);
         r.to_unit   = 5'($urandom);
         r.step_unit = 5'($urandom);
      end else if (r.mode == UNIT_EXACT) begin
         r.from_unit = 5'($urandom_range(0, 18));
         r.to_unit   = 5'($urandom_range(0, 18));
         r.step_unit = 5'($urandom_range(0, 18));
      end else begin
         if ($urandom_range(0, 1) == 0) begin
            r.from_unit = 5'($urandom_range(0, 9));
            r.to_unit   = 5'($urandom_range(0, 9));
         end else begin
            r.from_unit = 5'($urandom_range(10, 17));
            r.to_unit   = 5'($urandom_range(10, 17));
         end
         r.step_unit = 5'($urandom_range(10, 17));
      end
      return r;
   endfunction

   function automatic vector_type mk(input logic m, input logic [63:0] fv,
                                     input logic [4:0] fu, input logic [63:0] tv,
                                     input logic [4:0] tu, input logic [63:0] sv,
                                     input logic [4:0] su, input bit typed,
                                     input logic [63:0] cnt, input err_type e);
      vector_type v;
      v.row = '{m, fv, fu, tv, tu, sv, su};
      v.typed = typed;
      v.want = '{cnt, e};
      return v;
   endfunction

   // Present one item and hold it until accepted
   task automatic send_row(input row_type r, input bit typed, input count_type want);
      count_type predicted;
      predicted = count_rows(r);
      if (typed && (predicted.row_count != want.row_count ||
                    predicted.error_code != want.error_code)) begin
         $error("table row disagrees with prediction: count %0d/%0d err %0d/%0d",
                want.row_count, predicted.row_count, want.error_code,
                predicted.error_code);
         error_count++;
      end
      req_valid      <= 1'b1;
      req_mode       <= r.mode;
      req_from_value <= r.from_value;
      req_from_unit  <= r.from_unit;
      req_to_value   <= r.to_value;
      req_to_unit    <= r.to_unit;
      req_step_value <= r.step_value;
      req_step_unit  <= r.step_unit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_counts.push_back(typed ? want : predicted);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (!stall_enable) rsp_ready <= 1'b1;
      else rsp_ready <= (cycle_count % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      count_type exp_count;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            $error("result with no expectation: count %0d err %0d",
                   rsp_row_count, rsp_error_code);
            error_count++;
         end else begin
            exp_count = pending_counts.pop_front();
            if (rsp_row_count !== exp_count.row_count) begin
               $error("row_count expected %0d actual %0d",
                      exp_count.row_count, rsp_row_count);
               error_count++;
            end
            if (rsp_error_code !== exp_count.error_code) begin
               $error("error_code expected %0d actual %0d",
                      exp_count.error_code, rsp_error_code);
               error_count++;
            end
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   localparam logic [63:0] MAX_S = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   initial begin
      vector_type table_rows[$];
      row_type    r;
      int         burst;
      count_type  none;
      none = '{64'd0, ERR_NONE};
      error_count    = 0;
      cycle_count    = 0;
      stall_enable   = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = 1'b0;
      req_from_value = '0;
      req_from_unit  = '0;
      req_to_value   = '0;
      req_to_unit    = '0;
      req_step_value = '0;
      req_step_unit  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      table_rows.push_back(mk(UNIT_EXACT, 0, 0, 9, 0, 1, 0, 1, 10, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, 5, 0, 5, 0, 3, 0, 1, 1, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, 9, 0, 0, 0, 1, 0, 1, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, 0, 0, 9, 0, ALL_ONES, 0, 1, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, 9, 0, 0, 0, ALL_ONES, 0, 1, 10, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, 1, 0, 7, 0, 0, 0, 1, 0, ERR_ZERO_STEP));
      table_rows.push_back(mk(UNIT_EXACT, 1, 19, 7, 0, 1, 0, 1, 0, ERR_UNIT));
      table_rows.push_back(mk(UNIT_EXACT, 1, 0, 7, 0, 0, 31, 1, 0, ERR_UNIT));
      table_rows.push_back(mk(UNIT_EXACT, MIN_S, 0, MAX_S, 0, 1, 0, 1, 0, ERR_TOO_MANY));
      table_rows.push_back(mk(UNIT_EXACT, MIN_S, 0, MAX_S, 0, 2, 0, 1, MIN_S, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, 0, 0, MAX_S, 0, 1, 0, 1, MIN_S, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, MAX_S, 0, MIN_S, 0, MIN_S, 0, 0, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, 15, 1, 3, 0, 5, 18, 0, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, MIN_S, 18, MAX_S, 18, 1, 18, 0, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_EXACT, MIN_S, 0, MAX_S, 18, 1, 18, 0, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_TEMPORAL, 0, 9, 60, 0, 1, 13, 0, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_TEMPORAL, 0, 16, 1, 17, 1, 16, 0, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_TEMPORAL, 0, 10, 1, 17, 1, 10, 0, 0, ERR_NONE));
      table_rows.push_back(mk(UNIT_TEMPORAL, 0, 0, 1, 10, 1, 13, 1, 0, ERR_UNIT));
      table_rows.push_back(mk(UNIT_TEMPORAL, 0, 0, 1, 0, 1, 9, 1, 0, ERR_UNIT));
      table_rows.push_back(mk(UNIT_TEMPORAL, 0, 18, 1, 10, 1, 13, 1, 0, ERR_UNIT));
      table_rows.push_back(mk(UNIT_TEMPORAL, 0, 10, 1, 10, 0, 17, 1, 0, ERR_ZERO_STEP));
      table_rows.push_back(mk(UNIT_TEMPORAL, MIN_S, 10, MAX_S, 10, 1, 10, 1, 0,
                              ERR_TOO_MANY));
      table_rows.push_back(mk(UNIT_TEMPORAL, 5, 12, 0, 12, MIN_S, 17, 0, 0, ERR_NONE));
      foreach (table_rows[i]) send_row(table_rows[i].row, table_rows[i].typed,
                                       table_rows[i].want);

      // Hold off until the pipeline drains
      idle_sender(0);
      while (pending_counts.size() != 0) @(posedge clock);
      stall_enable = 1'b1;

      // Random rows in bursts with gaps
      for (int n = 0; n < 2000; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < 2000; b++, n++) begin
            r = random_row();
            send_row(r, 1'b0, none);
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
      end
      idle_sender(0);

      while (pending_counts.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_counts.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rcfd_pkg.sv
rtl/core/rcfd_divider.sv
rtl/core/range_count_floored_divider.sv
bench/range_count_floored_divider_test.sv
